/* design/assert_macros.svh */
// assert_macros.svh
// Assertion macros used by the transition count top level.
// No dependencies; simulation bodies vanish when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LTCM_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");
`define LTCM_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define LTCM_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define LTCM_ASSERT(lbl, clk, rst_n, cond)
`define LTCM_IMPLIES(lbl, clk, rst_n, ante, cons)
`define LTCM_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/ltcm_pkg.sv */
// ltcm_pkg.sv
// Shared types and fixed constants of the lagged transition count matrix.
// No dependencies.
package ltcm_pkg;

  localparam int CMD_W       = 2;
  localparam int IN_TUSER_W  = CMD_W + 1;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // register index, taken from the word address bit
  localparam logic CFG_IDX_LAG = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 2'd0,
    CMD_RD_COUNT = 2'd1,
    CMD_RD_TABLE = 2'd2
  } ltcm_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_UPD,
    S_RDCNT,
    S_HOLD
  } ltcm_state_t;

  typedef struct packed {
    logic shift;
    logic inject;
  } ltcm_dly_ctrl_t;

  typedef struct packed {
    logic old_hit;
    logic new_hit;
  } ltcm_hit_t;

endpackage

/* design/ltcm_delay_cell.sv */
// ltcm_delay_cell.sv
// One stage of the variable length sample delay line.
// Depends on ltcm_pkg for the control struct.
module ltcm_delay_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  ltcm_pkg::ltcm_dly_ctrl_t   ctrl,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic [SAMPLE_BITS-1:0]     neighbor,
  output logic [SAMPLE_BITS-1:0]     q
);

  logic [SAMPLE_BITS-1:0] q_r;

  // take the fresh sample at the tap point, else pass the neighbour on
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q_r <= ctrl.inject ? sample : neighbor;
    end
  end

  assign q = q_r;

endmodule

/* design/ltcm_table_cell.sv */
// ltcm_table_cell.sv
// One entry of the distinct value table with its two match comparators.
// Depends on ltcm_pkg for the hit struct.
module ltcm_table_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [SAMPLE_BITS-1:0]  wdata,
  input  logic                    occupied,
  input  logic [SAMPLE_BITS-1:0]  key_old,
  input  logic [SAMPLE_BITS-1:0]  key_new,
  output logic [SAMPLE_BITS-1:0]  value,
  output ltcm_pkg::ltcm_hit_t     hit
);

  logic [SAMPLE_BITS-1:0] value_r;

  always_ff @(posedge clk) begin
    if (we) begin
      value_r <= wdata;
    end
  end

  assign value = value_r;

  always_comb begin
    hit.old_hit = occupied && (value_r == key_old);
    hit.new_hit = occupied && (value_r == key_new);
  end

endmodule

/* design/ltcm_count_ram.sv */
// ltcm_count_ram.sv
// Count cell store: one write port, one read port with registered data.
// No dependencies.
module ltcm_count_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/lagged_transition_count_matrix.sv */
// lagged_transition_count_matrix.sv
// Top level: delay line and value table cell rows, count RAM, control FSM.
// Depends on ltcm_pkg, ltcm_delay_cell, ltcm_table_cell, ltcm_count_ram.
//
//  Channel | Ports         | Moves                        | Word layout (low bit up)
//  --------+---------------+------------------------------+------------------------------
//  input   | in_t*         | push / count read / tbl read | tdata: sample, row, col
//          |               |                              | tuser: command, new_trajectory
//  result  | out_t*        | one word per input word      | tdata: from, to, count,
//          |               |                              |   state value, distinct count
//          |               |                              | tuser: counted, table_full
//  config  | cfg_p* (APB)  | lag register at byte addr 0  | pwdata: lag
//
// Steps: a push that completes a lag window passes accept, lookup and count read,
// then write-back, and ends after the lookup if the table is full; other words end at
// accept, count reads in a RAM read state after it. Reset: the count RAM is swept to zero,
// one cell a cycle over all 2**(2*clog2(MAX_STATES)) cells (4096 at defaults), with in_tready low.
// Stalls: a finished word waits in the output register, a further one in a hold
// register that blocks new input until it moves on. Config writes go in any cycle.

`include "assert_macros.svh"

module lagged_transition_count_matrix #(
  parameter int MAX_STATES  = 64,
  parameter int MAX_LAG     = 63,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32,
  localparam int IDX_W       = $clog2(MAX_STATES),
  localparam int DIST_W      = $clog2(MAX_STATES + 1),
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 2 * IDX_W + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((2 * IDX_W + COUNT_BITS + SAMPLE_BITS + DIST_W + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_TDATA_W-1:0]              in_tdata,   // sample_value, row_index, col_index
  input  logic [ltcm_pkg::IN_TUSER_W-1:0]    in_tuser,   // command, new_trajectory
  // result words
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [OUT_TDATA_W-1:0]             out_tdata,  // from_index, to_index, count_value,
                                                         // state_value, distinct_count
  output logic [ltcm_pkg::OUT_TUSER_W-1:0]   out_tuser,  // transition_counted, table_full
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ltcm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ltcm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ltcm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  import ltcm_pkg::*;

  localparam int LAG_W   = $clog2(MAX_LAG + 1);
  localparam int FILL_W  = $clog2(MAX_LAG + 2);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int ROW_LO  = SAMPLE_BITS;
  localparam int COL_LO  = SAMPLE_BITS + IDX_W;
  localparam int CNT_LO  = 2 * IDX_W;

  localparam logic [LAG_W-1:0]  LAG_MAX   = LAG_W'(MAX_LAG);
  localparam logic [DIST_W-1:0] USED_FULL = DIST_W'(MAX_STATES);

  // ---------------------------------------------------------------- input unpack
  ltcm_cmd_t              in_cmd;
  logic                   in_new;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [IDX_W-1:0]       in_row;
  logic [IDX_W-1:0]       in_col;

  assign in_cmd    = ltcm_cmd_t'(in_tuser[CMD_W-1:0]);
  assign in_new    = in_tuser[CMD_W];
  assign in_sample = in_tdata[SAMPLE_BITS-1:0];
  assign in_row    = in_tdata[ROW_LO +: IDX_W];
  assign in_col    = in_tdata[COL_LO +: IDX_W];

  // ---------------------------------------------------------------- state
  ltcm_state_t state_r, state_nxt;

  logic [LAG_W-1:0]       lag_r, lag_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [DIST_W-1:0]      used_r, used_nxt;
  logic [ADDR_W-1:0]      clr_r, clr_nxt;
  logic [SAMPLE_BITS-1:0] okey_r, okey_nxt;
  logic [SAMPLE_BITS-1:0] nkey_r, nkey_nxt;
  logic [IDX_W-1:0]       idx_a_r, idx_a_nxt;
  logic [IDX_W-1:0]       idx_b_r, idx_b_nxt;
  logic                   rd_ok_r, rd_ok_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;
  logic [OUT_TDATA_W-1:0] hold_tdata_r, hold_tdata_nxt;
  logic [OUT_TUSER_W-1:0] hold_tuser_r, hold_tuser_nxt;

  // ---------------------------------------------------------------- config port
  logic             cfg_wr;
  logic             cfg_lag_hit;
  logic [LAG_W-1:0] cfg_lag_val;

  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_lag_hit = (cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_LAG);
  // keep the low LAG_W bits of the write data and clamp them to MAX_LAG; upper bits are dropped
  assign cfg_lag_val = (cfg_pwdata[LAG_W-1:0] > LAG_MAX) ? LAG_MAX : cfg_pwdata[LAG_W-1:0];
  assign cfg_prdata  = cfg_lag_hit ? CFG_DATA_W'(lag_r) : '0;

  // ---------------------------------------------------------------- delay line
  // The fresh sample enters at cell 'lag' and every older sample moves one
  // cell towards cell 0, so cell 0 always holds the sample lag pushes back.
  logic                   dl_shift;
  logic [SAMPLE_BITS-1:0] dl_q [MAX_LAG + 1];
  ltcm_dly_ctrl_t         dl_ctrl [MAX_LAG + 1];

  for (genvar k = 0; k <= MAX_LAG; k++) begin : g_dly
    logic [SAMPLE_BITS-1:0] nbr;
    if (k < MAX_LAG) begin : g_mid
      assign nbr = dl_q[k + 1];
    end else begin : g_end
      assign nbr = in_sample;
    end
    assign dl_ctrl[k] = '{shift: dl_shift, inject: (LAG_W'(k) == lag_r)};
    ltcm_delay_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (dl_ctrl[k]),
      .sample   (in_sample),
      .neighbor (nbr),
      .q        (dl_q[k])
    );
  end

  // ---------------------------------------------------------------- value table
  logic [MAX_STATES-1:0]  tc_we;
  logic [SAMPLE_BITS-1:0] tc_wd  [MAX_STATES];
  logic [MAX_STATES-1:0]  tc_occ;
  logic [SAMPLE_BITS-1:0] tc_val [MAX_STATES];
  ltcm_hit_t              tc_hit [MAX_STATES];

  for (genvar k = 0; k < MAX_STATES; k++) begin : g_tbl
    assign tc_occ[k] = (DIST_W'(k) < used_r);
    ltcm_table_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .we       (tc_we[k]),
      .wdata    (tc_wd[k]),
      .occupied (tc_occ[k]),
      .key_old  (okey_r),
      .key_new  (nkey_r),
      .value    (tc_val[k]),
      .hit      (tc_hit[k])
    );
  end

  // Table values are distinct, so at most one cell hits: OR the indices.
  logic             o_any, n_any;
  logic [IDX_W-1:0] o_idx, n_idx;
  logic [SAMPLE_BITS-1:0] tab_val;

  always_comb begin
    o_any   = 1'b0;
    n_any   = 1'b0;
    o_idx   = '0;
    n_idx   = '0;
    tab_val = '0;
    for (int k = 0; k < MAX_STATES; k++) begin
      if (tc_hit[k].old_hit) begin
        o_any = 1'b1;
        o_idx = o_idx | IDX_W'(k);
      end
      if (tc_hit[k].new_hit) begin
        n_any = 1'b1;
        n_idx = n_idx | IDX_W'(k);
      end
      if (IDX_W'(k) == in_row) begin
        tab_val = tc_val[k];
      end
    end
  end

  // ---------------------------------------------------------------- count RAM
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, cnt_inc;

  ltcm_count_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // saturate at the top of the count range
  assign cnt_inc = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

  // ---------------------------------------------------------------- control
  logic [FILL_W-1:0]      need;
  logic [FILL_W-1:0]      fill_base;
  logic                   keys_same;
  logic                   out_free;
  logic                   seed, o_app, n_app;
  logic [DIST_W-1:0]      used_o;
  logic [IDX_W-1:0]       look_fi, look_ti;
  logic                   look_ok;
  logic                   fin;
  logic                   res_counted, res_full;
  logic [IDX_W-1:0]       res_from, res_to;
  logic [COUNT_BITS-1:0]  res_count;
  logic [SAMPLE_BITS-1:0] res_state;
  logic [DIST_W-1:0]      res_dist;
  logic [OUT_TDATA_W-1:0] res_tdata;
  logic [OUT_TUSER_W-1:0] res_tuser;

  assign need      = FILL_W'(lag_r) + FILL_W'(1);
  assign fill_base = in_new ? '0 : fill_r;
  assign keys_same = (okey_r == nkey_r);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    lag_nxt        = lag_r;
    fill_nxt       = fill_r;
    used_nxt       = used_r;
    clr_nxt        = clr_r;
    okey_nxt       = okey_r;
    nkey_nxt       = nkey_r;
    idx_a_nxt      = idx_a_r;
    idx_b_nxt      = idx_b_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    hold_tdata_nxt = hold_tdata_r;
    hold_tuser_nxt = hold_tuser_r;

    dl_shift  = 1'b0;
    seed      = 1'b0;
    o_app     = 1'b0;
    n_app     = 1'b0;
    used_o    = used_r;
    look_fi   = '0;
    look_ti   = '0;
    look_ok   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {in_row, in_col};

    fin         = 1'b0;
    res_counted = 1'b0;
    res_full    = 1'b0;
    res_from    = '0;
    res_to      = '0;
    res_count   = '0;
    res_state   = '0;
    res_dist    = used_r;

    case (state_r)
      S_CLEAR: begin
        // sweep the count RAM to zero
        ram_we  = 1'b1;
        clr_nxt = clr_r + ADDR_W'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          case (in_cmd)
            CMD_PUSH: begin
              // the first sample after reset claims table entry 0
              seed = (used_r == '0);
              if (seed) begin
                used_nxt = DIST_W'(1);
              end
              dl_shift = 1'b1;
              fill_nxt = (fill_base < need) ? fill_base + FILL_W'(1) : fill_base;
              okey_nxt = (lag_r == '0) ? in_sample : dl_q[1];
              nkey_nxt = in_sample;
              if (fill_nxt == need) begin
                state_nxt = S_LOOK;
              end else begin
                fin      = 1'b1;
                res_dist = used_nxt;
              end
            end
            CMD_RD_COUNT: begin
              ram_re    = 1'b1;
              idx_a_nxt = in_row;
              idx_b_nxt = in_col;
              rd_ok_nxt = (DIST_W'(in_row) < USED_FULL) && (DIST_W'(in_col) < USED_FULL);
              state_nxt = S_RDCNT;
            end
            CMD_RD_TABLE: begin
              fin      = 1'b1;
              res_from = in_row;
              if (DIST_W'(in_row) < used_r) begin
                res_state = tab_val;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_LOOK: begin
        // oldest first: a miss appends it before the newest is looked at
        o_app   = !o_any && (used_r != USED_FULL);
        look_fi = o_any ? o_idx : used_r[IDX_W-1:0];
        used_o  = used_r + DIST_W'(o_app);
        look_ti = look_fi;
        if (o_any || o_app) begin
          if (keys_same) begin
            look_ok = 1'b1;
          end else if (n_any) begin
            look_ti = n_idx;
            look_ok = 1'b1;
          end else if (used_o != USED_FULL) begin
            look_ti = used_o[IDX_W-1:0];
            n_app   = 1'b1;
            look_ok = 1'b1;
          end
        end
        used_nxt = used_o + DIST_W'(n_app);
        if (look_ok) begin
          ram_re    = 1'b1;
          ram_raddr = {look_fi, look_ti};
          idx_a_nxt = look_fi;
          idx_b_nxt = look_ti;
          state_nxt = S_UPD;
        end else begin
          fin      = 1'b1;
          res_full = 1'b1;
          res_dist = used_nxt;
        end
      end

      S_UPD: begin
        ram_we      = 1'b1;
        ram_waddr   = {idx_a_r, idx_b_r};
        ram_wdata   = cnt_inc;
        fin         = 1'b1;
        res_counted = 1'b1;
        res_from    = idx_a_r;
        res_to      = idx_b_r;
        res_count   = cnt_inc;
      end

      S_RDCNT: begin
        fin      = 1'b1;
        res_from = idx_a_r;
        res_to   = idx_b_r;
        if (rd_ok_r) begin
          res_count = ram_rdata;
        end
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = hold_tdata_r;
          out_tuser_nxt = hold_tuser_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_tdata = OUT_TDATA_W'({res_dist, res_state, res_count, res_to, res_from});
    res_tuser = {res_full, res_counted};

    // hand the finished word to the output register, or park it
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_tdata_nxt = res_tdata;
        out_tuser_nxt = res_tuser;
        state_nxt     = S_IDLE;
      end else begin
        hold_tdata_nxt = res_tdata;
        hold_tuser_nxt = res_tuser;
        state_nxt      = S_HOLD;
      end
    end

    // a lag write restarts the window
    if (cfg_wr && cfg_lag_hit) begin
      lag_nxt  = cfg_lag_val;
      fill_nxt = '0;
    end
  end

  // write enables of the table cells: seed, then oldest and newest appends
  always_comb begin
    for (int k = 0; k < MAX_STATES; k++) begin
      tc_we[k] = 1'b0;
      tc_wd[k] = okey_r;
      if (seed && (k == 0)) begin
        tc_we[k] = 1'b1;
        tc_wd[k] = in_sample;
      end
      if (o_app && (DIST_W'(k) == used_r)) begin
        tc_we[k] = 1'b1;
        tc_wd[k] = okey_r;
      end
      if (n_app && (DIST_W'(k) == used_o)) begin
        tc_we[k] = 1'b1;
        tc_wd[k] = nkey_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r       <= LAG_W'(1);
      fill_r      <= '0;
      used_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lag_r       <= lag_nxt;
      fill_r      <= fill_nxt;
      used_r      <= used_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okey_r       <= okey_nxt;
    nkey_r       <= nkey_nxt;
    idx_a_r      <= idx_a_nxt;
    idx_b_r      <= idx_b_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
    hold_tdata_r <= hold_tdata_nxt;
    hold_tuser_r <= hold_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------- checks
  logic [COUNT_BITS-1:0] out_count;

  assign out_count = out_tdata_r[CNT_LO +: COUNT_BITS];

  `LTCM_ASSERT(a_used_bound, clk, rst_n, used_r <= USED_FULL)
  `LTCM_ASSERT(a_fill_bound, clk, rst_n, fill_r <= need)
  `LTCM_NEXT(a_used_grows, clk, rst_n, 1'b1, used_r >= $past(used_r))
  `LTCM_IMPLIES(a_count_nonzero, clk, rst_n, out_valid_r && out_tuser_r[0], out_count != '0)

endmodule

/* tb/lagged_transition_count_matrix_tb.sv */
// Self-checking bench for the lagged transition count matrix: push, count read, table read
// and unused-command words against an in-bench tally of windows, table and count cells.
// Depends on ltcm_pkg and the lagged_transition_count_matrix RTL.
`timescale 1ns / 1ps

module lagged_transition_count_matrix_tb;
  import ltcm_pkg::*;

  localparam int N_STATES   = 64;
  localparam int N_LAG_MAX  = 63;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int N_DIRECTED = 18;
  localparam int N_TYPED    = 5;   // leading rows whose result is written out by hand
  localparam int N_PHASES   = 6;
  localparam int N_POOL     = 24;
  localparam int SETTLE     = 8;   // cycles past the last result before going quiet

  localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] LAG_ADDR   = {CFG_ADDR_W{1'b0}} | (CFG_IDX_LAG << 2);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] sample;
    logic        newtraj;
    logic [5:0]  row;
    logic [5:0]  col;
  } word_t;

  typedef struct packed {
    logic        counted;
    logic [5:0]  from_idx;
    logic [5:0]  to_idx;
    logic [31:0] count_val;
    logic [15:0] state_val;
    logic        full;
    logic [6:0]  dist_cnt;
  } result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;      // sample_value, row_index, col_index
  logic [IN_TUSER_W-1:0] in_tuser;     // command, new_trajectory
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;    // from, to, count, state value, distinct count
  logic [OUT_TUSER_W-1:0] out_tuser;   // transition_counted, table_full
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  lagged_transition_count_matrix dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Tally of the block: lag, sample window, value table and count cells.
  int          lag_now;
  logic [15:0] window [N_LAG_MAX+1];
  int          fill;
  logic [15:0] state_table [N_STATES];
  int          used;
  logic [31:0] cell_count [N_STATES*N_STATES];

  result_t     due_results [$];
  logic [15:0] fresh_pool [N_POOL];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;

  word_t   dir_word [N_DIRECTED];
  result_t dir_want [N_TYPED];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop well beyond the slowest correct run (clear sweep plus stalls on every word).
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Look a value up in the table, appending it when absent; 0 when no entry is free.
  function automatic bit find_or_add(input logic [15:0] v, output int idx);
    int k;
    idx = 0;
    for (k = 0; k < used; k++) begin
      if (state_table[k] == v) begin
        idx = k;
        return 1'b1;
      end
    end
    if (used >= N_STATES) return 1'b0;
    state_table[used] = v;
    idx = used;
    used++;
    return 1'b1;
  endfunction

  // Advance the tally by one accepted word and return the result word it yields.
  function automatic result_t tally_word(input word_t w);
    result_t r;
    int need;
    int fi;
    int ti;
    int k;
    bit ok;
    r = '0;
    case (w.cmd)
      CMD_PUSH: begin
        need = lag_now + 1;
        // the very first sample after reset claims table entry zero
        if (used == 0) begin
          state_table[0] = w.sample;
          used = 1;
        end
        if (w.newtraj) fill = 0;
        if (fill < need) begin
          window[fill] = w.sample;
          fill++;
        end else begin
          for (k = 0; k < need - 1; k++) window[k] = window[k+1];
          window[need-1] = w.sample;
        end
        if (fill == need) begin
          // oldest first: it stays in the table even if the newest then misses
          ok = find_or_add(window[0], fi);
          if (ok) ok = find_or_add(window[need-1], ti);
          if (ok) begin
            if (cell_count[fi*N_STATES+ti] != '1) cell_count[fi*N_STATES+ti]++;
            r.counted   = 1'b1;
            r.from_idx  = 6'(fi);
            r.to_idx    = 6'(ti);
            r.count_val = cell_count[fi*N_STATES+ti];
          end else begin
            r.full = 1'b1;
          end
        end
      end
      CMD_RD_COUNT: begin
        r.from_idx  = w.row;
        r.to_idx    = w.col;
        r.count_val = cell_count[w.row*N_STATES+w.col];
      end
      CMD_RD_TABLE: begin
        r.from_idx = w.row;
        if (w.row < used) r.state_val = state_table[w.row];
      end
      default: ;
    endcase
    r.dist_cnt = 7'(used);
    return r;
  endfunction

  // Mostly values already held, so windows keep landing on known states;
  // the rest grows the table until it overflows.
  function automatic logic [15:0] pick_sample();
    int p;
    p = $urandom_range(99);
    if (used > 0 && p < 70) return state_table[$urandom_range(used - 1)];
    if (p < 85) return fresh_pool[$urandom_range(N_POOL - 1)];
    return 16'($urandom);
  endfunction

  function automatic word_t random_word();
    word_t w;
    int p;
    p = $urandom_range(99);
    if (p < 70)      w.cmd = CMD_PUSH;
    else if (p < 82) w.cmd = CMD_RD_COUNT;
    else if (p < 94) w.cmd = CMD_RD_TABLE;
    else             w.cmd = CMD_UNUSED;
    w.sample  = pick_sample();
    w.newtraj = ($urandom_range(lag_now * 2 + 24) == 0);
    w.row     = 6'($urandom);
    w.col     = 6'($urandom);
    // aim most count reads at cells that can actually hold something
    if (w.cmd == CMD_RD_COUNT && used > 0 && $urandom_range(3) != 0) begin
      w.row = 6'($urandom_range(used - 1));
      w.col = 6'($urandom_range(used - 1));
    end
    return w;
  endfunction

  // Offer one word from a falling edge; return at the falling edge after acceptance.
  task automatic send_word(input word_t w, input bit typed, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, w.col, w.row, w.sample};
    in_tuser  <= {w.newtraj, w.cmd};
    do @(posedge clk); while (!in_tready);
    if (typed) begin
      void'(tally_word(w));
      due_results = {due_results, want};
    end else begin
      due_results = {due_results, tally_word(w)};
    end
    @(negedge clk);
  endtask

  // Hold off the sender until every pending result word has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write the lag register while idle, then read it back.
  task automatic write_lag(input int v);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= LAG_ADDR;
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    lag_now = (v > N_LAG_MAX) ? N_LAG_MAX : v;
    fill    = 0;   // a lag write empties the window
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== lag_now) begin
      $error("lag: expected %0d actual %0d", lag_now, cfg_prdata);
      errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Receiver: drop tready at random per the current idling mix.
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Compare every accepted result word with the oldest one pending.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("result word arrived with none pending");
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("transition_counted", want.counted, out_tuser[0]);
        check_field("table_full", want.full, out_tuser[1]);
        check_field("from_index", want.from_idx, out_tdata[5:0]);
        check_field("to_index", want.to_idx, out_tdata[11:6]);
        check_field("count_value", want.count_val, out_tdata[43:12]);
        check_field("state_value", want.state_val, out_tdata[59:44]);
        check_field("distinct_count", want.dist_cnt, out_tdata[66:60]);
      end
    end
  end

  initial begin : stimulus
    int k;
    int ph;
    int n;
    int lag_plan [N_PHASES];
    int phase_len [N_PHASES];

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    errors      = 0;

    // tally starts from the reset state
    lag_now = 1;
    fill    = 0;
    used    = 0;
    for (k = 0; k <= N_LAG_MAX; k++) window[k] = '0;
    for (k = 0; k < N_STATES; k++) state_table[k] = '0;
    for (k = 0; k < N_STATES * N_STATES; k++) cell_count[k] = '0;
    for (k = 0; k < N_POOL; k++) fresh_pool[k] = 16'($urandom);

    // Directed words at the reset lag of one: reads of the cleared store, the
    // unused command, extreme samples, a trajectory restart, a self transition
    // and reads past the filled part of the table.
    dir_word = '{
      '{CMD_RD_COUNT, 16'h0000, 1'b0, 6'd0,  6'd0},
      '{CMD_RD_TABLE, 16'h0000, 1'b0, 6'd0,  6'd0},
      '{CMD_UNUSED,   16'hFFFF, 1'b1, 6'd63, 6'd63},
      '{CMD_PUSH,     16'h8000, 1'b1, 6'd0,  6'd0},
      '{CMD_PUSH,     16'h7FFF, 1'b0, 6'd0,  6'd0},
      '{CMD_PUSH,     16'h7FFF, 1'b0, 6'd0,  6'd0},
      '{CMD_PUSH,     16'h0000, 1'b0, 6'd63, 6'd63},
      '{CMD_PUSH,     16'hFFFF, 1'b1, 6'd0,  6'd0},
      '{CMD_PUSH,     16'h0001, 1'b0, 6'd21, 6'd42},
      '{CMD_RD_COUNT, 16'h0000, 1'b0, 6'd0,  6'd1},
      '{CMD_RD_COUNT, 16'hFFFF, 1'b1, 6'd63, 6'd63},
      '{CMD_RD_TABLE, 16'h0000, 1'b0, 6'd0,  6'd0},
      '{CMD_RD_TABLE, 16'h0000, 1'b0, 6'd63, 6'd0},
      '{CMD_RD_TABLE, 16'h0000, 1'b0, 6'd4,  6'd0},
      '{CMD_PUSH,     16'h0001, 1'b1, 6'd0,  6'd0},
      '{CMD_PUSH,     16'h0001, 1'b0, 6'd0,  6'd0},
      '{CMD_UNUSED,   16'h0000, 1'b0, 6'd0,  6'd0},
      '{CMD_RD_COUNT, 16'h0000, 1'b0, 6'd4,  6'd4}
    };
    // After reset everything reads zero; the first push claims entry zero, and
    // the second completes the first window as cell (0,1) with count one.
    dir_want = '{
      '{1'b0, 6'd0, 6'd0, 32'd0, 16'h0000, 1'b0, 7'd0},
      '{1'b0, 6'd0, 6'd0, 32'd0, 16'h0000, 1'b0, 7'd0},
      '{1'b0, 6'd0, 6'd0, 32'd0, 16'h0000, 1'b0, 7'd0},
      '{1'b0, 6'd0, 6'd0, 32'd0, 16'h0000, 1'b0, 7'd1},
      '{1'b1, 6'd0, 6'd1, 32'd1, 16'h0000, 1'b0, 7'd2}
    };

    lag_plan  = '{0, N_LAG_MAX, $urandom_range(2, 20), $urandom_range(21, 62), 1, 0};
    phase_len = '{130, 220, 130, 120, 130, 120};

    // sender idles a little, receiver a lot
    send_idle_pct = 7;
    recv_idle_pct = 68;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // tready stays low through the clearing sweep; the handshake waits it out
    for (k = 0; k < N_DIRECTED; k++)
      send_word(dir_word[k], k < N_TYPED, (k < N_TYPED) ? dir_want[k] : '0);

    for (ph = 0; ph < N_PHASES; ph++) begin
      write_lag(lag_plan[ph]);
      case (ph / 2)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (n = 0; n < phase_len[ph]; n++) begin
        // pause mid-phase until the result side has fully caught up
        if (ph == 2 && n == 60) drain();
        send_word(random_word(), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
